/* rtl/bsuf_pkg.sv */
// ----------------------------------------------------------------------------
// bsuf_pkg
// Shared types and constants for the scaled unit formatter: widths, mode
// codes, register indexes, controller states and the control bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package bsuf_pkg;

  // field and datapath widths
  localparam int unsigned ValueW   = 64;
  localparam int unsigned WholeW   = 10;
  localparam int unsigned TenthsW  = 4;
  localparam int unsigned UnitW    = 4;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned RemW     = 10;
  localparam int unsigned BaseW    = RemW + 1;
  localparam int unsigned RoundW   = 14;

  // long division by the si base: quotient bits retired per cycle
  localparam int unsigned DigitW   = 8;
  localparam int unsigned DivSteps = ValueW / DigitW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam int unsigned MaxUnitsDef = 8;

  localparam logic [BaseW-1:0]  BaseSi   = 11'd1000;
  localparam logic [BaseW-1:0]  BaseIec  = 11'd1024;
  localparam logic [WholeW-1:0] WholeMax = 10'd1023;
  localparam logic [3:0]        TenVal   = 4'd10;

  // unit mode codes
  localparam logic [ModeW-1:0] UnitSi   = 2'd0;
  localparam logic [ModeW-1:0] UnitIec  = 2'd1;
  localparam logic [ModeW-1:0] UnitIecI = 2'd2;

  // rounding mode codes
  localparam logic [ModeW-1:0] RoundUp   = 2'd0;
  localparam logic [ModeW-1:0] RoundDown = 2'd1;
  localparam logic [ModeW-1:0] RoundNear = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgUnitMode  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgRoundMode = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StCheck,
    StDiv,
    StDone
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clear_rem;
    logic shift_step;
    logic div_step;
    logic div_last;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic more;
    logic pow2_base;
  } status_t;

endpackage

`default_nettype wire

/* rtl/binary_to_scaled_unit_format.sv */
// ----------------------------------------------------------------------------
// binary_to_scaled_unit_format
// Turns an unsigned 64-bit value into a scaled whole part, tenths digit and
// unit suffix index, dividing by 1000 or 1024 up to MaxUnits times.
//
//   channel  | signals                                   | handshake
//   ---------+-------------------------------------------+-------------------
//   input    | value_i                                   | start, busy
//   result   | whole_part_o tenths_digit_o tenths_shown_o| out_strobe_o
//            | unit_index_o binary_marker_o              |
//   config   | cfg_index_i cfg_data_i                    | cfg_valid_i/ready_o
//
// A word is taken when start is high and busy is low. Base 1024 takes one
// shifter step per unit; base 1000 takes, per unit, a check and then the
// bytewise long divider's 8 quotient-byte steps. The strobe lasts one
// cycle; the receiver cannot stall.
// Reset puts unit mode at iec and rounding at up.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_scaled_unit_format #(
  parameter int unsigned MaxUnits = bsuf_pkg::MaxUnitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [bsuf_pkg::ValueW-1:0]   value_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [bsuf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [bsuf_pkg::ModeW-1:0]    cfg_data_i,
  output logic                               out_strobe_o,
  output logic [bsuf_pkg::WholeW-1:0]        whole_part_o,
  output logic [bsuf_pkg::TenthsW-1:0]       tenths_digit_o,
  output logic                               tenths_shown_o,
  output logic [bsuf_pkg::UnitW-1:0]         unit_index_o,
  output logic                               binary_marker_o
);

  bsuf_pkg::cmd_t    cmd;
  bsuf_pkg::status_t status;

  logic [bsuf_pkg::ModeW-1:0] unit_mode_q, unit_mode_d;
  logic [bsuf_pkg::ModeW-1:0] round_mode_q, round_mode_d;

  assign cfg_ready_o = 1'b1;

  // decode configuration writes
  always_comb begin
    unit_mode_d  = unit_mode_q;
    round_mode_d = round_mode_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bsuf_pkg::CfgUnitMode:  unit_mode_d  = cfg_data_i;
        bsuf_pkg::CfgRoundMode: round_mode_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_mode_q  <= bsuf_pkg::UnitIec;
      round_mode_q <= bsuf_pkg::RoundUp;
    end else begin
      unit_mode_q  <= unit_mode_d;
      round_mode_q <= round_mode_d;
    end
  end

  bsuf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  bsuf_dpath #(
    .MaxUnits (MaxUnits)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .value_i         (value_i),
    .unit_mode_i     (unit_mode_q),
    .rounding_mode_i (round_mode_q),
    .out_strobe_o    (out_strobe_o),
    .whole_part_o    (whole_part_o),
    .tenths_digit_o  (tenths_digit_o),
    .tenths_shown_o  (tenths_shown_o),
    .unit_index_o    (unit_index_o),
    .binary_marker_o (binary_marker_o)
  );

  // a result appears only once the sequencer is back at rest
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_strobe_o |-> !busy)
    else $error("result strobe while busy");

  // an accepted word always leaves the sequencer busy in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("accepted word did not start the sequencer");

  // the strobe is never held high
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_strobe_o |=> !out_strobe_o)
    else $error("result strobe held");

  // unscaled results carry no tenths and no marker
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && (unit_index_o == '0)) |-> (!tenths_shown_o && !binary_marker_o))
    else $error("unscaled result with tenths or marker");

  // the unit index stays within the configured limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> (unit_index_o <= bsuf_pkg::UnitW'(MaxUnits)))
    else $error("unit index beyond limit");

endmodule

`default_nettype wire

/* rtl/bsuf_ctrl.sv */
// ----------------------------------------------------------------------------
// bsuf_ctrl
// Sequencer: loads a word, repeats base divisions while the datapath asks
// for more, runs the bytewise long division for base 1000, then finishes.
// ----------------------------------------------------------------------------
`default_nettype none

module bsuf_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  bsuf_pkg::status_t      status_i,
  output bsuf_pkg::cmd_t         cmd_o
);

  bsuf_pkg::state_e state_q, state_d;
  logic [bsuf_pkg::DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic div_last;

  assign div_last = (div_cnt_q == bsuf_pkg::DivCntW'(bsuf_pkg::DivSteps - 1));
  assign busy     = (state_q != bsuf_pkg::StIdle);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bsuf_pkg::StIdle: begin
        if (start) state_d = bsuf_pkg::StCheck;
      end
      bsuf_pkg::StCheck: begin
        if (!status_i.more) state_d = bsuf_pkg::StDone;
        else if (!status_i.pow2_base) state_d = bsuf_pkg::StDiv;
      end
      bsuf_pkg::StDiv: begin
        if (div_last) state_d = bsuf_pkg::StCheck;
      end
      bsuf_pkg::StDone: begin
        state_d = bsuf_pkg::StIdle;
      end
      default: state_d = bsuf_pkg::StIdle;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      bsuf_pkg::StIdle: begin
        cmd_o.load = start;
      end
      bsuf_pkg::StCheck: begin
        cmd_o.shift_step = status_i.more && status_i.pow2_base;
        cmd_o.clear_rem  = status_i.more && !status_i.pow2_base;
      end
      bsuf_pkg::StDiv: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_last = div_last;
      end
      bsuf_pkg::StDone: begin
        cmd_o.finish = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  // advance the byte counter inside a division
  always_comb begin
    div_cnt_d = div_cnt_q;
    if (state_q == bsuf_pkg::StDiv) div_cnt_d = div_cnt_q + 1'b1;
    else div_cnt_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bsuf_pkg::StIdle;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/bsuf_dpath.sv */
// ----------------------------------------------------------------------------
// bsuf_dpath
// Quotient, remainder and unit count registers, the divide-by-1024 shift,
// the bytewise divide-by-1000 step, and the rounding and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bsuf_dpath #(
  parameter int unsigned MaxUnits = bsuf_pkg::MaxUnitsDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  bsuf_pkg::cmd_t                          cmd_i,
  output bsuf_pkg::status_t                       status_o,
  input  wire logic [bsuf_pkg::ValueW-1:0]        value_i,
  input  wire logic [bsuf_pkg::ModeW-1:0]         unit_mode_i,
  input  wire logic [bsuf_pkg::ModeW-1:0]         rounding_mode_i,
  output logic                                    out_strobe_o,
  output logic [bsuf_pkg::WholeW-1:0]             whole_part_o,
  output logic [bsuf_pkg::TenthsW-1:0]            tenths_digit_o,
  output logic                                    tenths_shown_o,
  output logic [bsuf_pkg::UnitW-1:0]              unit_index_o,
  output logic                                    binary_marker_o
);

  logic [bsuf_pkg::ValueW-1:0] n_q, n_d;
  logic [bsuf_pkg::RemW-1:0]   rem_q, rem_d;
  logic [bsuf_pkg::UnitW-1:0]  units_q, units_d;
  logic                        strobe_q;

  logic [bsuf_pkg::WholeW-1:0]  whole_q, whole_d;
  logic [bsuf_pkg::TenthsW-1:0] tenths_q, tenths_d;
  logic                         shown_q, shown_d;
  logic [bsuf_pkg::UnitW-1:0]   unit_q, unit_d;
  logic                         marker_q, marker_d;

  logic [bsuf_pkg::BaseW-1:0]  base;
  logic                        below_max;

  // divide-by-1000 step signals
  logic [bsuf_pkg::RemW-1:0]   div_r;
  logic [bsuf_pkg::BaseW-1:0]  div_t;
  logic [bsuf_pkg::DigitW-1:0] div_q;

  assign base = (unit_mode_i == bsuf_pkg::UnitSi) ? bsuf_pkg::BaseSi : bsuf_pkg::BaseIec;
  assign below_max = (units_q < bsuf_pkg::UnitW'(MaxUnits));

  assign status_o.pow2_base = (unit_mode_i != bsuf_pkg::UnitSi);
  assign status_o.more      = (n_q >= bsuf_pkg::ValueW'(base)) && below_max;

  // retire one quotient byte, top bits first
  always_comb begin
    div_r = rem_q;
    div_t = '0;
    div_q = '0;
    for (int i = bsuf_pkg::DigitW - 1; i >= 0; i--) begin
      div_t = {div_r, n_q[bsuf_pkg::ValueW - bsuf_pkg::DigitW + i]};
      if (div_t >= bsuf_pkg::BaseSi) begin
        div_r    = bsuf_pkg::RemW'(div_t - bsuf_pkg::BaseSi);
        div_q[i] = 1'b1;
      end else begin
        div_r    = div_t[bsuf_pkg::RemW-1:0];
        div_q[i] = 1'b0;
      end
    end
  end

  // quotient, remainder and unit count
  always_comb begin
    n_d     = n_q;
    rem_d   = rem_q;
    units_d = units_q;
    if (cmd_i.load) begin
      n_d     = value_i;
      rem_d   = '0;
      units_d = '0;
    end else if (cmd_i.shift_step) begin
      n_d     = n_q >> bsuf_pkg::RemW;
      rem_d   = n_q[bsuf_pkg::RemW-1:0];
      units_d = units_q + 1'b1;
    end else if (cmd_i.clear_rem) begin
      rem_d   = '0;
    end else if (cmd_i.div_step) begin
      n_d     = {n_q[bsuf_pkg::ValueW-bsuf_pkg::DigitW-1:0], div_q};
      rem_d   = div_r;
      if (cmd_i.div_last) units_d = units_q + 1'b1;
    end
  end

  // rounding of the last remainder
  logic [bsuf_pkg::BaseW-1:0]  bias;
  logic [bsuf_pkg::RoundW-1:0] scaled_rem;
  logic [bsuf_pkg::RoundW-1:0] thr;
  logic [bsuf_pkg::TenthsW-1:0] tenths_raw;
  logic                        whole_inc;
  logic [bsuf_pkg::ValueW:0]   whole_sum;
  logic [bsuf_pkg::TenthsW-1:0] small_sum;

  always_comb begin
    unique case (rounding_mode_i)
      bsuf_pkg::RoundDown: begin
        bias      = '0;
        whole_inc = 1'b0;
      end
      bsuf_pkg::RoundNear: begin
        bias      = base >> 1;
        whole_inc = ({rem_q, 1'b0} >= base);
      end
      default: begin
        bias      = base - 1'b1;
        whole_inc = (rem_q != '0);
      end
    endcase
    scaled_rem = (bsuf_pkg::RoundW'(rem_q) << 3) + (bsuf_pkg::RoundW'(rem_q) << 1)
               + bsuf_pkg::RoundW'(bias);
    // count base multiples in the scaled remainder (at most ten)
    tenths_raw = '0;
    for (int k = 1; k <= 10; k++) begin
      thr = bsuf_pkg::RoundW'(base) * bsuf_pkg::RoundW'(k);
      if (scaled_rem >= thr) tenths_raw = tenths_raw + 1'b1;
    end
    whole_sum = {1'b0, n_q} + (bsuf_pkg::ValueW + 1)'(whole_inc);
    small_sum = n_q[bsuf_pkg::TenthsW-1:0] + 1'b1;
  end

  // result fields
  always_comb begin
    whole_d  = n_q[bsuf_pkg::WholeW-1:0];
    tenths_d = '0;
    shown_d  = 1'b0;
    unit_d   = units_q;
    marker_d = (unit_mode_i == bsuf_pkg::UnitIecI) && (units_q != '0);
    if (units_q == '0) begin
      // unscaled: raw value, no suffix
      whole_d = n_q[bsuf_pkg::WholeW-1:0];
    end else if (n_q < bsuf_pkg::ValueW'(bsuf_pkg::TenVal)) begin
      if (tenths_raw >= bsuf_pkg::TenVal) begin
        // tenths carry into the whole part; tenths stay shown (as zero) unless it reaches ten
        whole_d = bsuf_pkg::WholeW'(small_sum);
        shown_d = (small_sum < bsuf_pkg::TenVal);
      end else begin
        whole_d  = n_q[bsuf_pkg::WholeW-1:0];
        tenths_d = tenths_raw;
        shown_d  = 1'b1;
      end
    end else if ((whole_sum >= (bsuf_pkg::ValueW + 1)'(base)) && below_max) begin
      // whole part reached the base: renormalize to 1.0 of the next unit
      whole_d = bsuf_pkg::WholeW'(1);
      shown_d = 1'b1;
      unit_d  = units_q + 1'b1;
    end else if (whole_sum > (bsuf_pkg::ValueW + 1)'(bsuf_pkg::WholeMax)) begin
      whole_d = bsuf_pkg::WholeMax;
    end else begin
      whole_d = whole_sum[bsuf_pkg::WholeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      units_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      units_q  <= units_d;
      strobe_q <= cmd_i.finish;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    rem_q <= rem_d;
    if (cmd_i.finish) begin
      whole_q  <= whole_d;
      tenths_q <= tenths_d;
      shown_q  <= shown_d;
      unit_q   <= unit_d;
      marker_q <= marker_d;
    end
  end

  assign out_strobe_o    = strobe_q;
  assign whole_part_o    = whole_q;
  assign tenths_digit_o  = tenths_q;
  assign tenths_shown_o  = shown_q;
  assign unit_index_o    = unit_q;
  assign binary_marker_o = marker_q;

endmodule

`default_nettype wire
